/* hdl/sbt_pkg.sv */
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, constants and helpers of the source byte tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package sbt_pkg;

   localparam int MAX_SOURCE_BYTES = 1048576;
   localparam int KW_MAX           = 7;
   localparam int KW_COUNT         = 26;
   localparam int MAX_TOKENS       = 4;
   localparam int QUEUE_DEPTH      = 4;

   localparam int OFF_W  = 20;
   localparam int LEN_W  = 21;
   localparam int KIND_W = 6;
   localparam int CNT_W  = $clog2(MAX_TOKENS + 1);
   localparam int TIX_W  = $clog2(MAX_TOKENS);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OFF_W-1:0]  start;
      logic [LEN_W-1:0]  length;
      logic [LEN_W-1:0]  line;
   } tok_type;

   // All tokens caused by one source byte
   typedef struct packed {
      logic [CNT_W-1:0]               count;
      tok_type [MAX_TOKENS-1:0]       tok;
   } bundle_type;

   typedef logic [KW_MAX-1:0][7:0] kbuf_type;

   localparam int KW_LEN [KW_COUNT] = '{
      6, 2, 6, 6, 7, 4, 6, 2, 2, 4, 5, 5, 6, 3, 2, 4, 4, 4, 5, 4, 6, 4, 3, 2, 4, 5
   };

   localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
      "define", "as", "number", "string", "boolean", "echo", "listen", "if",
      "ef", "else", "while", "until", "repeat", "for", "up", "down", "stop",
      "skip", "clear", "func", "struct", "calc", "and", "or", "true", "false"
   };

   // Character i of keyword k, zero past its end
   function automatic logic [7:0] kw_char(int k, int i);
      logic [8*KW_MAX-1:0] t;
      int                  s;
      t = KW_TEXT[k];
      s = KW_LEN[k] - 1 - i;
      if (s < 0) return 8'h00;
      return t[8*s +: 8];
   endfunction

   // Append one token to a bundle; extra tokens are dropped
   function automatic bundle_type add_tok(bundle_type b, logic [KIND_W-1:0] k,
                                          logic [OFF_W-1:0] s, logic [LEN_W-1:0] l,
                                          logic [LEN_W-1:0] ln);
      bundle_type r;
      r = b;
      if (r.count < CNT_W'(MAX_TOKENS)) begin
         r.tok[r.count[TIX_W-1:0]].kind   = k;
         r.tok[r.count[TIX_W-1:0]].start  = s;
         r.tok[r.count[TIX_W-1:0]].length = l;
         r.tok[r.count[TIX_W-1:0]].line   = ln;
         r.count = r.count + CNT_W'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/sbt_front.sv */
// ----------------------------------------------------------------------------
// sbt_front
// Scanner: classifies one source byte per accepted item and builds the
// bundle of tokens it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_front import sbt_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       source_byte,
   input  wire logic             final_byte,
   output bundle_type            bundle
);

   localparam logic [2:0] MODE_IDLE     = 3'd0;
   localparam logic [2:0] MODE_IDENT    = 3'd1;
   localparam logic [2:0] MODE_NUMBER   = 3'd2;
   localparam logic [2:0] MODE_OPERATOR = 3'd3;
   localparam logic [2:0] MODE_COMMENT  = 3'd4;
   localparam logic [2:0] MODE_STRING   = 3'd5;

   localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd26;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd27;
   localparam logic [KIND_W-1:0] KIND_STRING  = 6'd28;
   localparam logic [KIND_W-1:0] KIND_NEWLINE = 6'd29;
   localparam logic [KIND_W-1:0] KIND_EQ_EQ   = 6'd30;
   localparam logic [KIND_W-1:0] KIND_EQ      = 6'd31;
   localparam logic [KIND_W-1:0] KIND_NE      = 6'd32;
   localparam logic [KIND_W-1:0] KIND_LE      = 6'd33;
   localparam logic [KIND_W-1:0] KIND_LT      = 6'd34;
   localparam logic [KIND_W-1:0] KIND_GE      = 6'd35;
   localparam logic [KIND_W-1:0] KIND_GT      = 6'd36;
   localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd37;
   localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd38;
   localparam logic [KIND_W-1:0] KIND_STAR    = 6'd39;
   localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd40;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd41;
   localparam logic [KIND_W-1:0] KIND_DOT     = 6'd42;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd43;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd44;
   localparam logic [KIND_W-1:0] KIND_LBRACE  = 6'd45;
   localparam logic [KIND_W-1:0] KIND_RBRACE  = 6'd46;
   localparam logic [KIND_W-1:0] KIND_LBRACK  = 6'd47;
   localparam logic [KIND_W-1:0] KIND_RBRACK  = 6'd48;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 6'd49;
   localparam logic [KIND_W-1:0] KIND_END     = 6'd50;

   localparam logic [LEN_W-1:0] POS_MAX = LEN_W'(MAX_SOURCE_BYTES);
   localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_SOURCE_BYTES - 1);
   localparam int               KIX_W   = $clog2(KW_MAX);

   logic [2:0]        mode_ff, mode_in;
   logic [7:0]        pend_ff, pend_in;
   logic [1:0]        held_ff, held_in;
   logic [OFF_W-1:0]  begin_ff, begin_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  line_ff, line_in;
   kbuf_type          kbuf_ff, kbuf_in;

   function automatic logic [LEN_W-1:0] sub_sat(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   function automatic logic [OFF_W-1:0] clamp_off(logic [LEN_W-1:0] v);
      return (v > LEN_W'(OFF_MAX)) ? OFF_MAX : v[OFF_W-1:0];
   endfunction

   function automatic logic [KIND_W-1:0] word_kind(kbuf_type kb, logic [LEN_W-1:0] len);
      logic [KIND_W-1:0] k;
      logic              hit;
      k = KIND_IDENT;
      for (int w = KW_COUNT - 1; w >= 0; w--) begin
         hit = (len == LEN_W'(KW_LEN[w]));
         for (int i = 0; i < KW_MAX; i++) begin
            if (i < KW_LEN[w] && kb[i] != kw_char(w, i)) hit = 1'b0;
         end
         if (hit) k = KIND_W'(w);
      end
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] single_kind(logic [7:0] p);
      logic [KIND_W-1:0] k;
      priority case (p)
         "=":     k = KIND_EQ;
         "<":     k = KIND_LT;
         ">":     k = KIND_GT;
         "/":     k = KIND_SLASH;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] sym_kind(logic [7:0] c);
      logic [KIND_W-1:0] k;
      priority case (c)
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         ",":     k = KIND_COMMA;
         ".":     k = KIND_DOT;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         "[":     k = KIND_LBRACK;
         "]":     k = KIND_RBRACK;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   always_comb begin
      logic [7:0]       c;
      logic [OFF_W-1:0] here;
      logic [LEN_W-1:0] here_w;
      logic [LEN_W-1:0] idx;
      logic [LEN_W-1:0] first;
      logic [LEN_W-1:0] endp;
      logic             do_idle;
      logic             skip;
      bundle_type       b;

      c        = source_byte;
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      held_in  = held_ff;
      begin_in = begin_ff;
      line_in  = line_ff;
      kbuf_in  = kbuf_ff;
      b        = '0;
      do_idle  = 1'b0;
      skip     = 1'b0;
      first    = '0;
      here     = clamp_off(pos_ff);
      here_w   = LEN_W'(here);
      idx      = sub_sat(here_w, LEN_W'(begin_ff));
      pos_in   = (pos_ff < POS_MAX) ? pos_ff + LEN_W'(1) : pos_ff;
      endp     = pos_in;

      unique case (mode_ff)
         MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
               if (idx < LEN_W'(KW_MAX)) kbuf_in[idx[KIX_W-1:0]] = c;
            end else begin
               b = add_tok(b, word_kind(kbuf_ff, idx), begin_ff, idx, line_in);
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (!(is_digit(c) || c == ".")) begin
               b = add_tok(b, KIND_NUMBER, begin_ff, idx, line_in);
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_OPERATOR: begin
            pend_in = 8'h00;
            mode_in = MODE_IDLE;
            if (pend_ff == "/" && c == "/") begin
               mode_in = MODE_COMMENT;
            end else if (c == "=" && pend_ff != "/") begin
               b = add_tok(b, (pend_ff == "=") ? KIND_EQ_EQ :
                              (pend_ff == "!") ? KIND_NE :
                              (pend_ff == "<") ? KIND_LE : KIND_GE,
                           begin_ff, LEN_W'(2), line_in);
            end else begin
               b = add_tok(b, single_kind(pend_ff), begin_ff, LEN_W'(1), line_in);
               do_idle = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (c == 8'h0A) begin
               mode_in = MODE_IDLE;
               do_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            if (held_ff == 2'd1) begin
               if (c == 8'h80) begin
                  held_in = 2'd2;
                  skip    = 1'b1;
               end else begin
                  held_in = 2'd0;
               end
            end else if (held_ff == 2'd2) begin
               if (c == 8'h9C || c == 8'h9D) begin
                  b = add_tok(b, KIND_STRING, begin_ff,
                              sub_sat(sub_sat(here_w, LEN_W'(2)), LEN_W'(begin_ff)),
                              line_in);
                  mode_in = MODE_IDLE;
                  held_in = 2'd0;
                  skip    = 1'b1;
               end else begin
                  held_in = 2'd0;
               end
            end
            if (!skip) begin
               if (c == "\"") begin
                  b = add_tok(b, KIND_STRING, begin_ff, idx, line_in);
                  mode_in = MODE_IDLE;
                  held_in = 2'd0;
               end else if (c == 8'hE2) begin
                  held_in = 2'd1;
               end else if (c == 8'h0A) begin
                  if (line_in < POS_MAX) line_in = line_in + LEN_W'(1);
               end
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            do_idle = 1'b1;
         end
      endcase

      if (do_idle) begin
         if (held_in == 2'd1 && c == 8'h80) begin
            held_in = 2'd2;
         end else if (held_in == 2'd2 && (c == 8'h9C || c == 8'h9D)) begin
            held_in  = 2'd0;
            mode_in  = MODE_STRING;
            begin_in = clamp_off(here_w + LEN_W'(1));
         end else begin
            // broken curly quote: one unknown token per held byte
            if (held_in != 2'd0) begin
               first = sub_sat(here_w, LEN_W'(held_in));
               b = add_tok(b, KIND_UNKNOWN, first[OFF_W-1:0], LEN_W'(1), line_in);
               if (held_in == 2'd2)
                  b = add_tok(b, KIND_UNKNOWN, clamp_off(first + LEN_W'(1)),
                              LEN_W'(1), line_in);
               held_in = 2'd0;
            end
            if (c == 8'hE2) begin
               held_in = 2'd1;
            end else if (c == " " || c == 8'h0D || c == 8'h09) begin
               held_in = 2'd0;
            end else if (c == 8'h0A) begin
               b = add_tok(b, KIND_NEWLINE, here, LEN_W'(1), line_in);
               if (line_in < POS_MAX) line_in = line_in + LEN_W'(1);
            end else if (is_digit(c)) begin
               mode_in  = MODE_NUMBER;
               begin_in = here;
            end else if (is_alpha(c) || c == "_") begin
               mode_in    = MODE_IDENT;
               begin_in   = here;
               kbuf_in    = '0;
               kbuf_in[0] = c;
            end else if (c == "\"") begin
               mode_in  = MODE_STRING;
               begin_in = clamp_off(here_w + LEN_W'(1));
            end else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "/") begin
               mode_in  = MODE_OPERATOR;
               pend_in  = c;
               begin_in = here;
            end else begin
               b = add_tok(b, sym_kind(c), here, LEN_W'(1), line_in);
            end
         end
      end

      if (final_byte) begin
         unique case (mode_in)
            MODE_IDENT:
               b = add_tok(b, word_kind(kbuf_in, sub_sat(endp, LEN_W'(begin_in))),
                           begin_in, sub_sat(endp, LEN_W'(begin_in)), line_in);
            MODE_NUMBER:
               b = add_tok(b, KIND_NUMBER, begin_in, sub_sat(endp, LEN_W'(begin_in)),
                           line_in);
            MODE_OPERATOR:
               b = add_tok(b, single_kind(pend_in), begin_in, LEN_W'(1), line_in);
            MODE_STRING:
               b = add_tok(b, KIND_STRING, begin_in, sub_sat(endp, LEN_W'(begin_in)),
                           line_in);
            MODE_IDLE: begin
               if (held_in != 2'd0) begin
                  first = sub_sat(endp, LEN_W'(held_in));
                  b = add_tok(b, KIND_UNKNOWN, first[OFF_W-1:0], LEN_W'(1), line_in);
                  if (held_in == 2'd2)
                     b = add_tok(b, KIND_UNKNOWN, clamp_off(first + LEN_W'(1)),
                                 LEN_W'(1), line_in);
               end
            end
            default: b = b;
         endcase
         b = add_tok(b, KIND_END, clamp_off(endp), '0, line_in);
         // start a fresh source
         mode_in  = MODE_IDLE;
         pend_in  = 8'h00;
         held_in  = 2'd0;
         begin_in = '0;
         pos_in   = '0;
         line_in  = LEN_W'(1);
         kbuf_in  = '0;
      end

      bundle = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= 8'h00;
         held_ff  <= 2'd0;
         begin_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= LEN_W'(1);
         kbuf_ff  <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         held_ff  <= held_in;
         begin_ff <= begin_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
         kbuf_ff  <= kbuf_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/sbt_back.sv */
// ----------------------------------------------------------------------------
// sbt_back
// Bundle queue and token serializer: holds token bundles and hands them out
// one token per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module sbt_back import sbt_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type bundle,
   output logic            full,
   output logic            empty,
   input  wire logic       pop,
   output tok_type         token,
   output logic            last
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   bundle_type        store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [TIX_W-1:0]  sub_ff, sub_in;
   bundle_type        head;
   logic              take;

   assign head  = store_ff[rd_ff];
   assign full  = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign token = head.tok[sub_ff];
   assign last  = (CNT_W'(sub_ff) + CNT_W'(1) == head.count);
   assign take  = pop && !empty;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      sub_in  = sub_ff;
      fill_in = fill_ff;
      if (push) wr_in = wr_ff + PTR_W'(1);
      if (take) begin
         if (last) begin
            // bundle done: advance to the next one
            rd_in  = rd_ff + PTR_W'(1);
            sub_in = '0;
         end else begin
            sub_in = sub_ff + TIX_W'(1);
         end
      end
      if (push && !(take && last)) fill_in = fill_ff + FILL_W'(1);
      else if (!push && take && last) fill_in = fill_ff - FILL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
         sub_ff  <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
         sub_ff  <= sub_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/source_byte_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_byte_tokenizer
// Streaming lexer: one source byte in, zero to four tokens out.
//
//   Channel   Handshake         Payload
//   req_      push / full       source_byte, final_byte
//   rsp_      pop / empty       token_kind, token_start, token_length,
//                               token_line, last_of_run
//
// A byte is scanned in the cycle it is accepted; its tokens are written to the
// bundle queue and appear on the result ports in order, one per pop.
// The scanner takes one byte per cycle while the four-entry bundle queue has
// room; bytes that cause several tokens drain one token per cycle while popped.
// Synchronous reset clears scanner state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module source_byte_tokenizer import sbt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [7:0]        req_source_byte,
   input  wire logic              req_final_byte,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic [KIND_W-1:0]      rsp_token_kind,
   output logic [OFF_W-1:0]       rsp_token_start,
   output logic [LEN_W-1:0]       rsp_token_length,
   output logic [LEN_W-1:0]       rsp_token_line,
   output logic                   rsp_last_of_run
);

   logic       accept;
   bundle_type bundle;
   tok_type    token;

   assign accept = req_push && !req_full;

   sbt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .source_byte (req_source_byte),
      .final_byte  (req_final_byte),
      .bundle      (bundle)
   );

   sbt_back u_back (
      .clock  (clock),
      .reset  (reset),
      .push   (accept && bundle.count != '0),
      .bundle (bundle),
      .full   (req_full),
      .empty  (rsp_empty),
      .pop    (rsp_pop),
      .token  (token),
      .last   (rsp_last_of_run)
   );

   assign rsp_token_kind   = token.kind;
   assign rsp_token_start  = token.start;
   assign rsp_token_length = token.length;
   assign rsp_token_line   = token.line;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Streams directed and random source text through the byte tokenizer, with
// random gaps on both channels, and checks every token field against a
// behavioral lexer running alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import sbt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_OP, SCAN_COMMENT, SCAN_STRING
   } scan_type;

   localparam logic [5:0] K_IDENT = 6'd26, K_NUMBER = 6'd27, K_STRING = 6'd28;
   localparam logic [5:0] K_NEWLINE = 6'd29, K_EQEQ = 6'd30, K_EQ = 6'd31;
   localparam logic [5:0] K_NE = 6'd32, K_LE = 6'd33, K_LT = 6'd34, K_GE = 6'd35;
   localparam logic [5:0] K_GT = 6'd36, K_SLASH = 6'd40, K_UNKNOWN = 6'd49;
   localparam logic [5:0] K_END = 6'd50;
   localparam longint OFF_MAX = MAX_SOURCE_BYTES - 1;

   typedef struct {
      logic [5:0]  kind;
      logic [19:0] start;
      logic [20:0] length;
      logic [20:0] line;
      logic        last;
   } token_type;

   class token_board;
      string      words[26];
      token_type  expected[$];
      int         errors, tokens_seen, bytes_seen;
      scan_type   mode;
      byte        pend_op;
      int         held;
      longint     tok_begin, byte_pos, line_no;
      byte        kbuf[7];
      int         made;

      function new();
         words = '{"define", "as", "number", "string", "boolean", "echo", "listen",
                   "if", "ef", "else", "while", "until", "repeat", "for", "up",
                   "down", "stop", "skip", "clear", "func", "struct", "calc", "and",
                   "or", "true", "false"};
         clear_state();
      endfunction

      function void clear_state();
         mode = SCAN_IDLE; pend_op = 0; held = 0; tok_begin = 0;
         byte_pos = 0; line_no = 1;
         foreach (kbuf[i]) kbuf[i] = 0;
      endfunction

      function longint clamp(longint v);
         return v > OFF_MAX ? OFF_MAX : v;
      endfunction

      function longint sub0(longint a, longint b);
         return a > b ? a - b : 0;
      endfunction

      function void add(logic [5:0] k, longint s, longint l);
         token_type t;
         if (made >= MAX_TOKENS) return;
         t.kind = k; t.start = s[19:0]; t.length = l[20:0];
         t.line = line_no[20:0]; t.last = 0;
         expected.insert(expected.size(), t);
         made++;
      endfunction

      function void bump_line();
         if (line_no < MAX_SOURCE_BYTES) line_no++;
      endfunction

      function bit is_alpha(byte c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_digit(byte c);
         return c >= "0" && c <= "9";
      endfunction

      function void add_word(longint stop_at);
         longint     len;
         logic [5:0] k;
         bit         same;
         len = sub0(stop_at, tok_begin);
         k = K_IDENT;
         if (len <= KW_MAX)
            for (int i = 25; i >= 0; i--) begin
               same = words[i].len() == len;
               for (int j = 0; j < len && same; j++)
                  if (kbuf[j] != words[i][j]) same = 0;
               if (same) k = 6'(i);
            end
         add(k, tok_begin, len);
      endfunction

      function void add_single(byte p);
         logic [5:0] k;
         case (p)
            "=": k = K_EQ;
            "<": k = K_LT;
            ">": k = K_GT;
            "/": k = K_SLASH;
            default: k = K_UNKNOWN;
         endcase
         add(k, tok_begin, 1);
      endfunction

      function void flush_held(longint after);
         longint first;
         first = sub0(after, held);
         if (held >= 1) add(K_UNKNOWN, first, 1);
         if (held >= 2) add(K_UNKNOWN, clamp(first + 1), 1);
         held = 0;
      endfunction

      function void scan_idle(byte c, longint here);
         logic [5:0] k;
         if (held == 1 && c == 8'h80) begin held = 2; return; end
         if (held == 2 && (c == 8'h9C || c == 8'h9D)) begin
            held = 0; mode = SCAN_STRING; tok_begin = clamp(here + 1); return;
         end
         if (held > 0) flush_held(here);
         if (c == 8'hE2) begin held = 1; return; end
         if (c == " " || c == "\r" || c == "\t") return;
         if (c == "\n") begin add(K_NEWLINE, here, 1); bump_line(); return; end
         if (is_digit(c)) begin mode = SCAN_NUM; tok_begin = here; return; end
         if (is_alpha(c) || c == "_") begin
            mode = SCAN_WORD; tok_begin = here;
            foreach (kbuf[i]) kbuf[i] = 0;
            kbuf[0] = c;
            return;
         end
         if (c == "\"") begin mode = SCAN_STRING; tok_begin = clamp(here + 1); return; end
         if (c == "=" || c == "!" || c == "<" || c == ">" || c == "/") begin
            mode = SCAN_OP; pend_op = c; tok_begin = here; return;
         end
         case (c)
            "+": k = 6'd37;  "-": k = 6'd38;  "*": k = 6'd39;  ",": k = 6'd41;
            ".": k = 6'd42;  "(": k = 6'd43;  ")": k = 6'd44;  "{": k = 6'd45;
            "}": k = 6'd46;  "[": k = 6'd47;  "]": k = 6'd48;
            default: k = K_UNKNOWN;
         endcase
         add(k, here, 1);
      endfunction

      function void close_str(longint stop_at);
         add(K_STRING, tok_begin, sub0(stop_at, tok_begin));
         mode = SCAN_IDLE; held = 0;
      endfunction

      function void scan_string(byte c, longint here);
         if (held == 1) begin
            if (c == 8'h80) begin held = 2; return; end
            held = 0;
         end else if (held == 2) begin
            if (c == 8'h9C || c == 8'h9D) begin close_str(sub0(here, 2)); return; end
            held = 0;
         end
         if (c == "\"") begin close_str(here); return; end
         if (c == 8'hE2) begin held = 1; return; end
         if (c == "\n") bump_line();
      endfunction

      function void note_byte(byte c, bit fin);
         longint here, idx;
         byte    p;
         int     first;
         here = clamp(byte_pos);
         made = 0;
         first = expected.size();
         bytes_seen++;
         case (mode)
            SCAN_WORD:
               if (is_alpha(c) || is_digit(c) || c == "_") begin
                  idx = sub0(here, tok_begin);
                  if (idx < KW_MAX) kbuf[idx] = c;
               end else begin
                  add_word(here); mode = SCAN_IDLE; scan_idle(c, here);
               end
            SCAN_NUM:
               if (!(is_digit(c) || c == ".")) begin
                  add(K_NUMBER, tok_begin, sub0(here, tok_begin));
                  mode = SCAN_IDLE; scan_idle(c, here);
               end
            SCAN_OP: begin
               p = pend_op; pend_op = 0; mode = SCAN_IDLE;
               if (p == "/" && c == "/") mode = SCAN_COMMENT;
               else if (c == "=" && p != "/")
                  add(p == "=" ? K_EQEQ : p == "!" ? K_NE : p == "<" ? K_LE : K_GE,
                      tok_begin, 2);
               else begin
                  add_single(p); scan_idle(c, here);
               end
            end
            SCAN_COMMENT:
               if (c == "\n") begin mode = SCAN_IDLE; scan_idle(c, here); end
            SCAN_STRING: scan_string(c, here);
            default: scan_idle(c, here);
         endcase
         if (byte_pos < MAX_SOURCE_BYTES) byte_pos++;
         if (fin) begin
            case (mode)
               SCAN_WORD:   add_word(byte_pos);
               SCAN_NUM:    add(K_NUMBER, tok_begin, sub0(byte_pos, tok_begin));
               SCAN_OP:     add_single(pend_op);
               SCAN_STRING: add(K_STRING, tok_begin, sub0(byte_pos, tok_begin));
               SCAN_IDLE:   flush_held(byte_pos);
               default: ;
            endcase
            add(K_END, clamp(byte_pos), 0);
            clear_state();
         end
         if (expected.size() > first) expected[expected.size() - 1].last = 1;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_token(token_type got);
         token_type w;
         tokens_seen++;
         if (expected.size() == 0) begin
            report($sformatf("unexpected token kind %0d", got.kind));
            return;
         end
         w = expected.pop_front();
         if (got.kind !== w.kind)
            report($sformatf("kind %0d, want %0d", got.kind, w.kind));
         if (got.start !== w.start)
            report($sformatf("start %0d, want %0d", got.start, w.start));
         if (got.length !== w.length)
            report($sformatf("length %0d, want %0d", got.length, w.length));
         if (got.line !== w.line)
            report($sformatf("line %0d, want %0d", got.line, w.line));
         if (got.last !== w.last)
            report($sformatf("last_of_run %0b, want %0b", got.last, w.last));
      endtask
   endclass

   logic        clock = 0, reset = 1;
   logic        req_push = 0, req_final_byte = 0;
   logic [7:0]  req_source_byte = 0;
   logic        rsp_pop = 0;
   logic        req_full, rsp_empty, rsp_last_of_run;
   logic [KIND_W-1:0] rsp_token_kind;
   logic [OFF_W-1:0]  rsp_token_start;
   logic [LEN_W-1:0]  rsp_token_length, rsp_token_line;

   token_board board = new();
   bit         quiet = 0;
   int         cycles = 0;
   int         pop_hold = 0;
   int         sources = 0;

   source_byte_tokenizer uut (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 300000) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // receiver: check accepted tokens, stall in random bursts
   always @(posedge clock) begin
      token_type t;
      if (!reset && rsp_pop && !rsp_empty) begin
         t.kind = rsp_token_kind; t.start = rsp_token_start;
         t.length = rsp_token_length; t.line = rsp_token_line;
         t.last = rsp_last_of_run;
         board.check_token(t);
      end
      if (pop_hold > 0) begin
         pop_hold <= pop_hold - 1;
         rsp_pop <= 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         pop_hold <= $urandom_range(0, 5);
         rsp_pop <= 0;
      end else
         rsp_pop <= 1;
   end

   task send_byte(logic [7:0] b, bit fin);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push <= 1;
      req_source_byte <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_byte(b, fin);
   endtask

   task send_text(string s, bit fin);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && i == s.len() - 1);
   endtask

   task send_curly(bit closing, bit fin);
      send_byte(8'hE2, 0);
      send_byte(8'h80, 0);
      send_byte(closing ? 8'h9D : 8'h9C, fin);
   endtask

   // one random source: fragments of valid text mixed with noise
   task send_source();
      byte  piece[$];
      byte  all[$];
      int   n;
      string ops[15] = '{"==", "!=", "<=", ">=", "=", "<", ">", "/", "!", "+", "-",
                         "*", ",", "(", "]"};
      all.delete();
      n = $urandom_range(1, 8);
      for (int f = 0; f < n; f++) begin
         piece.delete();
         case ($urandom_range(0, 11))
            0, 1: begin
               string w;
               w = board.words[$urandom_range(0, 25)];
               foreach (w[i]) piece.insert(piece.size(), w[i]);
            end
            2: begin
               piece.insert(piece.size(),
                            $urandom_range(0, 1) ? "_" : 8'($urandom_range(97, 122)));
               repeat ($urandom_range(0, 10))
                  piece.insert(piece.size(),
                               $urandom_range(0, 2) == 0 ? 8'($urandom_range(48, 57))
                                                         : 8'($urandom_range(65, 90)));
            end
            3: repeat ($urandom_range(1, 5))
                  piece.insert(piece.size(),
                               $urandom_range(0, 3) == 0 ? "." : 8'($urandom_range(48, 57)));
            4: begin
               string o;
               o = ops[$urandom_range(0, 14)];
               foreach (o[i]) piece.insert(piece.size(), o[i]);
            end
            5: piece.insert(piece.size(), $urandom_range(0, 2) == 0 ? "\t" :
                                          $urandom_range(0, 1) ? " " : "\r");
            6: piece.insert(piece.size(), "\n");
            7: begin
               piece.insert(piece.size(), "/"); piece.insert(piece.size(), "/");
               repeat ($urandom_range(0, 4))
                  piece.insert(piece.size(), 8'($urandom_range(32, 126)));
            end
            8, 9: begin
               bit curly;
               curly = $urandom_range(0, 1);
               if (curly) begin
                  piece.insert(piece.size(), 8'hE2); piece.insert(piece.size(), 8'h80);
                  piece.insert(piece.size(), 8'h9C);
               end else piece.insert(piece.size(), "\"");
               repeat ($urandom_range(0, 4))
                  piece.insert(piece.size(),
                               $urandom_range(0, 4) == 0 ? "\n" : 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 5) != 0) begin
                  if ($urandom_range(0, 1)) begin
                     piece.insert(piece.size(), 8'hE2); piece.insert(piece.size(), 8'h80);
                     piece.insert(piece.size(), 8'h9D);
                  end else piece.insert(piece.size(), "\"");
               end
            end
            10: begin
               piece.insert(piece.size(), 8'hE2);
               if ($urandom_range(0, 1)) piece.insert(piece.size(), 8'h80);
               if ($urandom_range(0, 1))
                  piece.insert(piece.size(), 8'($urandom_range(0, 255)));
            end
            default: piece.insert(piece.size(), 8'($urandom_range(0, 255)));
         endcase
         all = {all, piece};
         if ($urandom_range(0, 2) == 0) all.insert(all.size(), " ");
      end
      foreach (all[i]) send_byte(all[i], i == all.size() - 1);
      sources++;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: keyword, ident, two-char op, slash pending at the end
      send_text("while _a7 !=3/", 1);
      // curly string across a newline, closed on the final byte
      send_curly(0, 0);
      send_text("x\n", 0);
      send_curly(1, 1);
      // broken curly quote, high byte, unterminated string
      send_byte(8'hE2, 0);
      send_byte(8'h80, 0);
      send_text("A", 0);
      send_byte(8'hFF, 0);
      send_text("\"q", 1);

      while (board.bytes_seen < 150) send_source();

      // hold until every token has drained
      req_push <= 0;
      while (board.expected.size() != 0) @(posedge clock);

      while (board.bytes_seen < 260) send_source();
      quiet = 1;
      while (board.bytes_seen < 310) send_source();
      req_push <= 0;

      while (board.expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d bytes in %0d random sources plus directed text",
               board.bytes_seen, sources);
      $display("checked %0d tokens, %0d mismatches", board.tokens_seen, board.errors);
      if (board.errors == 0 && board.expected.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire
